@@ hw/rtl/mfm_sbg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfm_sbg_pkg
// Shared constants, types and the CRC step for the MFM sector byte generator.
// ----------------------------------------------------------------------------
package mfm_sbg_pkg;

   // default geometry
   localparam int SECTOR_BYTES_DEFAULT = 256;
   localparam int TRAIL_GAP_DEFAULT    = 22;

   // fixed layout positions ahead of the data field
   localparam int POS_GAP1_END  = 22;
   localparam int POS_ID_SYNC   = 34;
   localparam int POS_ID_MARK   = 37;
   localparam int POS_TRACK     = 38;
   localparam int POS_SIDE      = 39;
   localparam int POS_SECT      = 40;
   localparam int POS_SIZE      = 41;
   localparam int POS_ID_CRC    = 42;
   localparam int POS_GAP2      = 44;
   localparam int POS_ZERO2     = 66;
   localparam int POS_DATA_SYNC = 74;
   localparam int POS_DATA_MARK = 77;
   localparam int POS_DATA      = 78;

   // stream byte codes
   localparam logic [7:0] BYTE_GAP       = 8'h4E;
   localparam logic [7:0] BYTE_ZERO      = 8'h00;
   localparam logic [7:0] BYTE_SYNC      = 8'hA1;
   localparam logic [7:0] BYTE_ID_MARK   = 8'hFE;
   localparam logic [7:0] BYTE_DATA_MARK = 8'hFB;

   // crc constants
   localparam logic [15:0] CRC_PRESET = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;

   // register interface
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_SIDE_NUMBER   = 2'd0,
      CSR_SECTOR_NUMBER = 2'd1,
      CSR_SIZE_CODE     = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   localparam logic [1:0] SIZE_CODE_RESET = 2'd1;

   // one byte of crc-16-ccitt, msb first
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/mfm_sector_byte_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfm_sector_byte_generator
// Raw IBM MFM sector byte stream source with running ID and data CRCs.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the req_ channel either asks for the next stream byte
//   (req_op = 0) or reports a head step (req_op = 1), which loads the track
//   number from req_new_track and restarts the sector at its first gap byte.
//   An emit request yields one response on the rsp_ channel carrying the byte
//   and a flag on the last trailing gap byte; a step request yields none.
//   Side, sector and size code of the ID field sit in three registers on the
//   APB port at byte addresses 0, 4 and 8; write them only while idle.
//   Latency: the response is valid in the cycle after its request is taken.
//   Throughput: one request per cycle while req_ready is high; byte, CRC step
//   and position update are all done in one pass from the state registers.
//   A single output register holds the response; while the receiver stalls,
//   req_ready stays low only as long as that register is full and not taken.
//   Reset clears position, track and CRC, sets size code to 1 and empties the
//   output register; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module mfm_sector_byte_generator #(
   parameter int SECTOR_BYTES = mfm_sbg_pkg::SECTOR_BYTES_DEFAULT,
   parameter int TRAIL_GAP    = mfm_sbg_pkg::TRAIL_GAP_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [7:0]                         req_new_track,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_data_byte,
   output logic                               rsp_last_of_sector,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mfm_sbg_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mfm_sbg_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mfm_sbg_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready
);

   // positions that follow from the geometry
   localparam int PosDataCrc = mfm_sbg_pkg::POS_DATA + SECTOR_BYTES;
   localparam int PosLast    = PosDataCrc + 1 + TRAIL_GAP;
   localparam int PosW       = $clog2(PosLast + 1);

   localparam logic [PosW-1:0] PGap1End  = PosW'(mfm_sbg_pkg::POS_GAP1_END);
   localparam logic [PosW-1:0] PIdSync   = PosW'(mfm_sbg_pkg::POS_ID_SYNC);
   localparam logic [PosW-1:0] PIdMark   = PosW'(mfm_sbg_pkg::POS_ID_MARK);
   localparam logic [PosW-1:0] PTrack    = PosW'(mfm_sbg_pkg::POS_TRACK);
   localparam logic [PosW-1:0] PSide     = PosW'(mfm_sbg_pkg::POS_SIDE);
   localparam logic [PosW-1:0] PSect     = PosW'(mfm_sbg_pkg::POS_SECT);
   localparam logic [PosW-1:0] PSize     = PosW'(mfm_sbg_pkg::POS_SIZE);
   localparam logic [PosW-1:0] PIdCrcHi  = PosW'(mfm_sbg_pkg::POS_ID_CRC);
   localparam logic [PosW-1:0] PIdCrcLo  = PosW'(mfm_sbg_pkg::POS_ID_CRC + 1);
   localparam logic [PosW-1:0] PZero2    = PosW'(mfm_sbg_pkg::POS_ZERO2);
   localparam logic [PosW-1:0] PDataSync = PosW'(mfm_sbg_pkg::POS_DATA_SYNC);
   localparam logic [PosW-1:0] PDataMark = PosW'(mfm_sbg_pkg::POS_DATA_MARK);
   localparam logic [PosW-1:0] PData     = PosW'(mfm_sbg_pkg::POS_DATA);
   localparam logic [PosW-1:0] PDCrcHi   = PosW'(PosDataCrc);
   localparam logic [PosW-1:0] PDCrcLo   = PosW'(PosDataCrc + 1);
   localparam logic [PosW-1:0] PLast     = PosW'(PosLast);

   // state
   logic [PosW-1:0] pos_ff, pos_in;
   logic [7:0]      track_ff, track_in;
   logic [15:0]     crc_ff, crc_in;
   logic            side_ff, side_in;
   logic [7:0]      sector_ff, sector_in;
   logic [1:0]      size_ff, size_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            req_take;
   logic            emit_take;
   logic [PosW-1:0] pos_cur;
   logic [PosW-1:0] data_idx;
   logic [7:0]      cur_byte;
   logic            cur_last;
   logic            csr_write;
   mfm_sbg_pkg::csr_index_type csr_idx;

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign emit_take = req_take && !req_op;

   // current position, guarded against running past the end
   assign pos_cur  = (pos_ff > PLast) ? '0 : pos_ff;
   assign data_idx = pos_cur - PData;
   assign cur_last = (pos_cur == PLast);

   // byte at the current position
   always_comb begin
      if (pos_cur < PGap1End) begin
         cur_byte = mfm_sbg_pkg::BYTE_GAP;
      end else if (pos_cur < PIdSync) begin
         cur_byte = mfm_sbg_pkg::BYTE_ZERO;
      end else if (pos_cur < PIdMark) begin
         cur_byte = mfm_sbg_pkg::BYTE_SYNC;
      end else if (pos_cur == PIdMark) begin
         cur_byte = mfm_sbg_pkg::BYTE_ID_MARK;
      end else if (pos_cur == PTrack) begin
         cur_byte = track_ff;
      end else if (pos_cur == PSide) begin
         cur_byte = {7'd0, side_ff};
      end else if (pos_cur == PSect) begin
         cur_byte = sector_ff;
      end else if (pos_cur == PSize) begin
         cur_byte = {6'd0, size_ff};
      end else if (pos_cur == PIdCrcHi) begin
         cur_byte = crc_ff[15:8];
      end else if (pos_cur == PIdCrcLo) begin
         cur_byte = crc_ff[7:0];
      end else if (pos_cur < PZero2) begin
         cur_byte = mfm_sbg_pkg::BYTE_GAP;
      end else if (pos_cur < PDataSync) begin
         cur_byte = mfm_sbg_pkg::BYTE_ZERO;
      end else if (pos_cur < PDataMark) begin
         cur_byte = mfm_sbg_pkg::BYTE_SYNC;
      end else if (pos_cur == PDataMark) begin
         cur_byte = mfm_sbg_pkg::BYTE_DATA_MARK;
      end else if (pos_cur < PDCrcHi) begin
         cur_byte = data_idx[7:0];
      end else if (pos_cur == PDCrcHi) begin
         cur_byte = crc_ff[15:8];
      end else if (pos_cur == PDCrcLo) begin
         cur_byte = crc_ff[7:0];
      end else begin
         cur_byte = mfm_sbg_pkg::BYTE_GAP;
      end
   end

   // position, track and crc update
   always_comb begin
      pos_in   = pos_ff;
      track_in = track_ff;
      crc_in   = crc_ff;
      if (req_take && req_op) begin
         track_in = req_new_track;
         pos_in   = '0;
      end else if (emit_take) begin
         pos_in = cur_last ? '0 : pos_cur + 1'b1;
         if (pos_cur == PIdSync || pos_cur == PDataSync) begin
            crc_in = mfm_sbg_pkg::crc_update(mfm_sbg_pkg::CRC_PRESET, cur_byte);
         end else if (pos_cur != PIdCrcHi && pos_cur != PIdCrcLo &&
                      pos_cur != PDCrcHi && pos_cur != PDCrcLo) begin
            crc_in = mfm_sbg_pkg::crc_update(crc_ff, cur_byte);
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_take) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = cur_last;
      end
   end

   // register port
   assign pready    = 1'b1;
   assign csr_idx   = mfm_sbg_pkg::csr_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      side_in   = side_ff;
      sector_in = sector_ff;
      size_in   = size_ff;
      if (csr_write) begin
         unique case (csr_idx)
            mfm_sbg_pkg::CSR_SIDE_NUMBER:   side_in   = pwdata[0];
            mfm_sbg_pkg::CSR_SECTOR_NUMBER: sector_in = pwdata[7:0];
            mfm_sbg_pkg::CSR_SIZE_CODE:     size_in   = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         mfm_sbg_pkg::CSR_SIDE_NUMBER:   prdata = {31'd0, side_ff};
         mfm_sbg_pkg::CSR_SECTOR_NUMBER: prdata = {24'd0, sector_ff};
         mfm_sbg_pkg::CSR_SIZE_CODE:     prdata = {30'd0, size_ff};
         default:                        prdata = '0;
      endcase
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         track_ff     <= '0;
         crc_ff       <= '0;
         side_ff      <= 1'b0;
         sector_ff    <= '0;
         size_ff      <= mfm_sbg_pkg::SIZE_CODE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         track_ff     <= track_in;
         crc_ff       <= crc_in;
         side_ff      <= side_in;
         sector_ff    <= sector_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_byte      = rsp_byte_ff;
   assign rsp_last_of_sector = rsp_last_ff;

   // checks
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PLast)
      else $error("position beyond end of sector");

   a_step_restarts: assert property (@(posedge clock) disable iff (reset)
      req_take && req_op |=> pos_ff == '0)
      else $error("head step did not restart the sector");

   a_wrap_at_last: assert property (@(posedge clock) disable iff (reset)
      emit_take && pos_ff == PLast |=> pos_ff == '0 && rsp_last_ff)
      else $error("no wrap after last byte");

   a_last_is_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_byte_ff == mfm_sbg_pkg::BYTE_GAP)
      else $error("last byte of sector is not gap");

   a_emit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      emit_take |=> rsp_valid_ff)
      else $error("emit request produced no response");

endmodule

@@ tb/mfm_sector_byte_generator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfm_sector_byte_generator_test
// Self-checking bench for the MFM sector byte generator. A shadow of the
// sector layout and the running CRC-16-CCITT predicts every stream byte and
// the end-of-sector flag. Requests come in bursts with random gaps, and the
// response side stalls on changing patterns. Runs cover head steps, whole
// sectors under extreme ID settings, the unused register slot and a long
// stream with random track changes.
// ----------------------------------------------------------------------------
module mfm_sector_byte_generator_test;

   // sector layout beyond the fixed positions in the package
   localparam int DATA_CRC_POS = mfm_sbg_pkg::POS_DATA + mfm_sbg_pkg::SECTOR_BYTES_DEFAULT;
   localparam int LAST_POS     = DATA_CRC_POS + 1 + mfm_sbg_pkg::TRAIL_GAP_DEFAULT;
   localparam int SECTOR_LEN   = LAST_POS + 1;

   localparam int CSR_ADDR_W = mfm_sbg_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = mfm_sbg_pkg::CSR_DATA_W;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int TIMEOUT_NS    = 5_000_000;

   typedef enum logic {
      OP_EMIT = 1'b0,
      OP_STEP = 1'b1
   } request_op_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_MASK,
      RX_COIN,
      RX_SPARSE
   } rx_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_of_sector;
   } stream_byte_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_op        = 1'b0;
   logic [7:0]            req_new_track = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [7:0]            rsp_data_byte;
   logic                  rsp_last_of_sector;
   logic                  psel          = 1'b0;
   logic                  penable       = 1'b0;
   logic                  pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr         = '0;
   logic [CSR_DATA_W-1:0] pwdata        = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // shadow of the generator state and its id field registers
   int unsigned       stream_pos  = 0;
   logic [7:0]        track_byte  = 8'h00;
   logic [15:0]       sector_crc  = 16'h0000;
   logic              side_reg    = 1'b0;
   logic [7:0]        sector_reg  = 8'h00;
   logic [1:0]        size_reg    = mfm_sbg_pkg::SIZE_CODE_RESET;
   stream_byte_type   expected_bytes[$];
   stream_byte_type   oldest_byte;

   int error_count    = 0;
   int requests_sent  = 0;
   int steps_sent     = 0;
   int bytes_checked  = 0;
   int wraps_seen     = 0;
   int settings_used  = 0;
   int burst_left     = 0;

   rx_mode_type rx_mode  = RX_OPEN;
   int          rx_left  = 0;
   int          rx_phase = 0;
   logic [15:0] rx_mask  = 16'hFFFF;

   mfm_sector_byte_generator u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_new_track      (req_new_track),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last_of_sector (rsp_last_of_sector),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // crc-16-ccitt over one byte, msb first
   function automatic logic [15:0] ccitt_byte(input logic [15:0] crc_in,
                                              input logic [7:0] value);
      logic [15:0] acc;
      acc = crc_in ^ {value, 8'h00};
      repeat (8) begin
         acc = acc[15] ? ({acc[14:0], 1'b0} ^ mfm_sbg_pkg::CRC_POLY)
                       : {acc[14:0], 1'b0};
      end
      return acc;
   endfunction

   // byte of the sector layout at a stream position
   function automatic logic [7:0] layout_byte(input int unsigned p);
      if (p < mfm_sbg_pkg::POS_GAP1_END)     return mfm_sbg_pkg::BYTE_GAP;
      if (p < mfm_sbg_pkg::POS_ID_SYNC)      return mfm_sbg_pkg::BYTE_ZERO;
      if (p < mfm_sbg_pkg::POS_ID_MARK)      return mfm_sbg_pkg::BYTE_SYNC;
      if (p == mfm_sbg_pkg::POS_ID_MARK)     return mfm_sbg_pkg::BYTE_ID_MARK;
      if (p == mfm_sbg_pkg::POS_TRACK)       return track_byte;
      if (p == mfm_sbg_pkg::POS_SIDE)        return {7'b0, side_reg};
      if (p == mfm_sbg_pkg::POS_SECT)        return sector_reg;
      if (p == mfm_sbg_pkg::POS_SIZE)        return {6'b0, size_reg};
      if (p == mfm_sbg_pkg::POS_ID_CRC)      return sector_crc[15:8];
      if (p == mfm_sbg_pkg::POS_ID_CRC + 1)  return sector_crc[7:0];
      if (p < mfm_sbg_pkg::POS_ZERO2)        return mfm_sbg_pkg::BYTE_GAP;
      if (p < mfm_sbg_pkg::POS_DATA_SYNC)    return mfm_sbg_pkg::BYTE_ZERO;
      if (p < mfm_sbg_pkg::POS_DATA_MARK)    return mfm_sbg_pkg::BYTE_SYNC;
      if (p == mfm_sbg_pkg::POS_DATA_MARK)   return mfm_sbg_pkg::BYTE_DATA_MARK;
      if (p < DATA_CRC_POS)                  return 8'(p - mfm_sbg_pkg::POS_DATA);
      if (p == DATA_CRC_POS)                 return sector_crc[15:8];
      if (p == DATA_CRC_POS + 1)             return sector_crc[7:0];
      return mfm_sbg_pkg::BYTE_GAP;
   endfunction

   // advance the shadow for one accepted request, queue the byte it yields
   task automatic predict_request(input request_op_type op, input logic [7:0] track);
      stream_byte_type res;
      int unsigned     p;
      if (op == OP_STEP) begin
         track_byte = track;
         stream_pos = 0;
      end else begin
         p = (stream_pos > LAST_POS) ? 0 : stream_pos;
         res.data_byte = layout_byte(p);
         // preset on the first sync byte, hold while the crc itself goes out
         if (p == mfm_sbg_pkg::POS_ID_SYNC || p == mfm_sbg_pkg::POS_DATA_SYNC) begin
            sector_crc = ccitt_byte(mfm_sbg_pkg::CRC_PRESET, res.data_byte);
         end else if (!(p == mfm_sbg_pkg::POS_ID_CRC || p == mfm_sbg_pkg::POS_ID_CRC + 1 ||
                        p == DATA_CRC_POS || p == DATA_CRC_POS + 1)) begin
            sector_crc = ccitt_byte(sector_crc, res.data_byte);
         end
         res.last_of_sector = (p == LAST_POS);
         stream_pos = res.last_of_sector ? 0 : p + 1;
         expected_bytes.push_back(res);
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // compare each accepted response with the oldest expected byte
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("response with no request pending", rsp_data_byte, 0);
         end else begin
            oldest_byte = expected_bytes.pop_front();
            if (rsp_data_byte !== oldest_byte.data_byte) begin
               report_mismatch($sformatf("data byte %0d", bytes_checked),
                               rsp_data_byte, oldest_byte.data_byte);
            end
            if (rsp_last_of_sector !== oldest_byte.last_of_sector) begin
               report_mismatch($sformatf("last flag %0d", bytes_checked),
                               rsp_last_of_sector, oldest_byte.last_of_sector);
            end
            if (oldest_byte.last_of_sector) wraps_seen++;
            bytes_checked++;
         end
      end
   end

   // response stalls: open, rotating mask, coin toss or sparse
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 200);
         rx_mask = 16'($urandom) | 16'h0001;
      end else begin
         rx_left--;
      end
      rx_phase = (rx_phase + 1) % 16;
      case (rx_mode)
         RX_OPEN: begin
            rsp_ready <= 1'b1;
         end
         RX_MASK: begin
            rsp_ready <= rx_mask[rx_phase];
         end
         RX_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   // bursts of random length, random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_request(input request_op_type op, input logic [7:0] track);
      pace_sender();
      req_valid     <= 1'b1;
      req_op        <= op;
      req_new_track <= track;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_request(op, track);
      requests_sent++;
      if (op == OP_STEP) steps_sent++;
   endtask

   task automatic emit_bytes(input int count);
      repeat (count) send_request(OP_EMIT, 8'($urandom));
   endtask

   // stop sending, let every response arrive, then let a step settle
   task automatic wait_stream_drained();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (expected_bytes.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (expected_bytes.size() != 0) begin
         report_mismatch("responses never arrived", expected_bytes.size(), 0);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input mfm_sbg_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         mfm_sbg_pkg::CSR_SIDE_NUMBER:   side_reg   = value[0];
         mfm_sbg_pkg::CSR_SECTOR_NUMBER: sector_reg = value[7:0];
         mfm_sbg_pkg::CSR_SIZE_CODE:     size_reg   = value[1:0];
         default: ;
      endcase
   endtask

   task automatic csr_read(input mfm_sbg_pkg::csr_index_type idx,
                           output logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // read back all three id field registers against the shadow
   task automatic check_registers();
      logic [CSR_DATA_W-1:0] value;
      csr_read(mfm_sbg_pkg::CSR_SIDE_NUMBER, value);
      if (value !== CSR_DATA_W'(side_reg)) report_mismatch("side register", value, side_reg);
      csr_read(mfm_sbg_pkg::CSR_SECTOR_NUMBER, value);
      if (value !== CSR_DATA_W'(sector_reg)) begin
         report_mismatch("sector register", value, sector_reg);
      end
      csr_read(mfm_sbg_pkg::CSR_SIZE_CODE, value);
      if (value !== CSR_DATA_W'(size_reg)) report_mismatch("size register", value, size_reg);
   endtask

   task automatic apply_settings(input logic side, input logic [7:0] sector,
                                 input logic [1:0] size);
      wait_stream_drained();
      csr_write(mfm_sbg_pkg::CSR_SIDE_NUMBER, CSR_DATA_W'(side));
      csr_write(mfm_sbg_pkg::CSR_SECTOR_NUMBER, CSR_DATA_W'(sector));
      csr_write(mfm_sbg_pkg::CSR_SIZE_CODE, CSR_DATA_W'(size));
      settings_used++;
      check_registers();
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_register_defaults();
      check_registers();
   endtask

   // bytes straight out of reset, head steps at track extremes, back-to-back steps
   task automatic test_step_and_gap_start();
      emit_bytes(2);
      send_request(OP_STEP, 8'hFF);
      emit_bytes(4);
      send_request(OP_STEP, 8'h00);
      send_request(OP_STEP, 8'h5A);
      emit_bytes(3);
      send_request(OP_STEP, 8'hA5);
      emit_bytes(6);
   endtask

   // a write past the last register must leave the others alone
   task automatic test_unused_register();
      wait_stream_drained();
      csr_write(mfm_sbg_pkg::CSR_UNUSED, '1);
      check_registers();
   endtask

   // one clean sector from a head step, through the wrap into the next
   task automatic test_full_sector(input logic side, input logic [7:0] sector,
                                   input logic [1:0] size, input logic [7:0] track);
      apply_settings(side, sector, size);
      send_request(OP_STEP, track);
      emit_bytes(SECTOR_LEN + 2);
   endtask

   // long stream with random settings and the odd head step
   task automatic test_random_stream();
      request_op_type op;
      repeat (2) begin
         apply_settings(1'($urandom), 8'($urandom), 2'($urandom));
         for (int i = 0; i < 115; i++) begin
            op = ($urandom_range(0, 99) == 0) ? OP_STEP : OP_EMIT;
            send_request(op, 8'($urandom));
            // hold off once per pass until the stream is fully drained
            if (i == 60) wait_stream_drained();
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_step_and_gap_start();
      test_unused_register();
      test_full_sector(1'b1, 8'hFF, 2'd3, 8'hFF);
      test_full_sector(1'b0, 8'h00, 2'd0, 8'h00);
      test_random_stream();
      wait_stream_drained();
      $display("covered %0d requests (%0d head steps), %0d bytes checked, %0d sector wraps",
               requests_sent, steps_sent, bytes_checked, wraps_seen);
      $display("id field settings applied: %0d, plus a write to the unused slot",
               settings_used);
      if (error_count == 0) begin
         $display("mfm_sector_byte_generator verification clean");
      end else begin
         $display("mfm_sector_byte_generator verification failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("mfm_sector_byte_generator verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/mfm_sbg_pkg.sv
hw/rtl/mfm_sector_byte_generator.sv
tb/mfm_sector_byte_generator_test.sv
